>>> rtl/core/hcd_pkg.sv
// Shared types, character codes and helpers for the chunked body decoder.
package hcd_pkg;

  localparam int unsigned LINE_W = 10;

  localparam logic [LINE_W-1:0] MAX_LINE_LEN_RST = 10'd256;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [2:0] {
    PH_SIZE         = 3'd0,
    PH_DATA         = 3'd1,
    PH_DATA_CR      = 3'd2,
    PH_DATA_LF      = 3'd3,
    PH_TRAILER      = 3'd4,
    PH_TRAILER_CR   = 3'd5,
    PH_TRAILER_LINE = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_DONE       = 2'd1,
    ST_ERROR      = 2'd2
  } status_e;

  typedef struct packed {
    logic    ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    status_e    status;
  } result_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (b inside {[8'h30:8'h39]}) begin
      h.val = b[3:0];
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      h.val = b[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> rtl/core/http_chunked_decoder.sv
// Top level of the HTTP chunked body decoder.
// One body byte per transaction in, one result per transaction out. The block
// sustains one byte per clock cycle unless out_ready_i holds the output; a
// byte passes the input register, then the parser state update into the result
// register. The parser state is updated once for each byte. status_o shows 0
// incomplete, 1 done, 2 error; done and error are sticky until reset. The user
// writes max_line_len through cfg_we_i only while idle; not enforced by the block.
module http_chunked_decoder
  import hcd_pkg::*;
#(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [LINE_W-1:0] cfg_max_line_len_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              data_valid_o,
  output logic [7:0]        data_byte_o,
  output logic [1:0]        status_o
);

  logic [LINE_W-1:0] max_line_len_q;
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              out_free;
  logic              fire;
  logic              out_valid_q, out_valid_d;
  result_t           res;
  result_t           res_q;

  assign out_free    = !out_valid_q || out_ready_i;
  assign fire        = s1_valid && out_free;
  assign out_valid_d = out_free ? s1_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_len_q <= MAX_LINE_LEN_RST;
    end else if (cfg_we_i) begin
      max_line_len_q <= cfg_max_line_len_i;
    end
  end

  hcd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .adv_i      (out_free),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  hcd_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .byte_i         (s1_byte),
    .max_line_len_i (max_line_len_q),
    .res_o          (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_valid_o = res_q.data_valid;
  assign data_byte_o  = res_q.data_byte;
  assign status_o     = res_q.status;

endmodule

>>> rtl/core/hcd_in_stage.sv
// Input register stage: holds one accepted byte until the parser takes it.
module hcd_in_stage
  import hcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       adv_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  assign in_ready_o = !valid_q || adv_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load ? 1'b1 : (adv_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

>>> rtl/core/hcd_parser.sv
// Parser state and single-byte next-state logic of the chunked decoder.
module hcd_parser
  import hcd_pkg::*;
#(
  parameter int unsigned SIZE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        byte_i,
  input  logic [LINE_W-1:0] max_line_len_i,
  output result_t           res_o
);

  phase_e                phase_q, phase_d;
  logic [SIZE_BITS-1:0]  rem_q, rem_d;
  logic                  seen_q, seen_d;
  logic                  ext_q, ext_d;
  logic [LINE_W-1:0]     line_q, line_d;
  status_e               status_q, status_d;
  logic                  dv;
  logic [LINE_W:0]       line_inc;
  hex_t                  hd;
  logic [SIZE_BITS-1:0]  rem_dec;

  assign line_inc = {1'b0, line_q} + {{LINE_W{1'b0}}, 1'b1};
  assign hd       = hex_digit(byte_i);
  assign rem_dec  = (rem_q != '0) ? rem_q - {{(SIZE_BITS-1){1'b0}}, 1'b1} : rem_q;

  always_comb begin
    phase_d  = phase_q;
    rem_d    = rem_q;
    seen_d   = seen_q;
    ext_d    = ext_q;
    line_d   = line_q;
    status_d = status_q;
    dv       = 1'b0;
    if (status_q == ST_INCOMPLETE) begin
      case (phase_q)
        PH_SIZE: begin
          if (line_inc > {1'b0, max_line_len_i}) begin
            status_d = ST_ERROR;
          end else begin
            line_d = line_inc[LINE_W-1:0];
            if (byte_i == CH_LF) begin
              if (!seen_q) begin
                status_d = ST_ERROR;
              end else begin
                phase_d = (rem_q == '0) ? PH_TRAILER : PH_DATA;
                ext_d   = 1'b0;
                line_d  = '0;
              end
            end else if (byte_i == CH_CR || ext_q) begin
              // skipped
            end else if (byte_i == CH_SEMI) begin
              if (!seen_q) begin
                status_d = ST_ERROR;
              end else begin
                ext_d = 1'b1;
              end
            end else if (!hd.ok) begin
              status_d = ST_ERROR;
            end else if (rem_q[SIZE_BITS-1 -: 4] != 4'd0) begin
              status_d = ST_ERROR;
            end else begin
              rem_d  = {rem_q[SIZE_BITS-5:0], hd.val};
              seen_d = 1'b1;
            end
          end
        end
        PH_DATA: begin
          dv    = 1'b1;
          rem_d = rem_dec;
          if (rem_dec == '0) begin
            phase_d = PH_DATA_CR;
          end
        end
        PH_DATA_CR, PH_DATA_LF: begin
          if (byte_i == CH_CR && phase_q == PH_DATA_CR) begin
            phase_d = PH_DATA_LF;
          end else if (byte_i == CH_LF) begin
            phase_d = PH_SIZE;
            seen_d  = 1'b0;
            ext_d   = 1'b0;
            line_d  = '0;
            rem_d   = '0;
          end else begin
            status_d = ST_ERROR;
          end
        end
        PH_TRAILER: begin
          if (byte_i == CH_LF) begin
            status_d = ST_DONE;
          end else if (byte_i == CH_CR) begin
            phase_d = PH_TRAILER_CR;
          end else begin
            phase_d = PH_TRAILER_LINE;
          end
        end
        PH_TRAILER_CR: begin
          status_d = (byte_i == CH_LF) ? ST_DONE : ST_ERROR;
        end
        PH_TRAILER_LINE: begin
          if (byte_i == CH_LF) begin
            phase_d = PH_TRAILER;
          end
        end
        default: begin
          status_d = ST_ERROR;
        end
      endcase
    end
    res_o.data_valid = dv;
    res_o.data_byte  = dv ? byte_i : 8'd0;
    res_o.status     = status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SIZE;
      rem_q    <= '0;
      seen_q   <= 1'b0;
      ext_q    <= 1'b0;
      line_q   <= '0;
      status_q <= ST_INCOMPLETE;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      rem_q    <= rem_d;
      seen_q   <= seen_d;
      ext_q    <= ext_d;
      line_q   <= line_d;
      status_q <= status_d;
    end
  end

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q == ST_DONE |=> status_q == ST_DONE)
    else $error("done status not sticky");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_q == ST_ERROR |=> status_q == ST_ERROR)
    else $error("error status not sticky");

  a_data_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA && status_q == ST_INCOMPLETE) |-> rem_q != '0)
    else $error("data phase with zero bytes left");

  a_valid_incomplete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.data_valid |-> res_o.status == ST_INCOMPLETE)
    else $error("payload byte passed after message end");

  a_line_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && phase_q == PH_SIZE && status_q == ST_INCOMPLETE
     && line_inc > {1'b0, max_line_len_i}) |=> status_q == ST_ERROR)
    else $error("overlong size line not flagged");

endmodule
